// ----- hw/rtl/ihs_pkg.sv -----
// Package for the image header sniffer: image type codes, signature bytes,
// format enable bit positions and the signature classifier. No dependencies.
package ihs_pkg;

    typedef logic [2:0] t_image_type;

    localparam t_image_type IMG_UNKNOWN = 3'd0;
    localparam t_image_type IMG_JPEG    = 3'd1;
    localparam t_image_type IMG_BMP     = 3'd2;
    localparam t_image_type IMG_PNG     = 3'd3;
    localparam t_image_type IMG_GIF     = 3'd4;

    localparam int EN_JPEG = 0;
    localparam int EN_BMP  = 1;
    localparam int EN_PNG  = 2;
    localparam int EN_GIF  = 3;

    localparam logic [7:0]  JPEG_MARK   = 8'hFF;
    localparam logic [7:0]  JPEG_SOI    = 8'hD8;
    localparam logic [7:0]  JPEG_SOF0   = 8'hC0;
    localparam logic [15:0] BMP_SIG     = 16'h4D42;
    localparam logic [63:0] PNG_SIG     = 64'h0A1A_0A0D_474E_5089;
    localparam logic [31:0] GIF_SIG     = 32'h3846_4947;

    localparam logic [4:0]  POS_SIG_END = 5'd8;
    localparam logic [4:0]  POS_LAST_SIG = 5'd7;
    localparam logic [4:0]  POS_PNG_DIM = 5'd16;
    localparam logic [4:0]  POS_PNG_END = 5'd23;
    localparam logic [4:0]  POS_BMP_DIM = 5'd18;
    localparam logic [4:0]  POS_BMP_END = 5'd25;
    localparam logic [4:0]  POS_MAX     = 5'd31;

    localparam logic [3:0]  SEG_IDLE    = 4'd0;
    localparam logic [3:0]  SEG_FIRST   = 4'd2;
    localparam logic [3:0]  SEG_H_HI    = 4'd5;
    localparam logic [3:0]  SEG_H_LO    = 4'd6;
    localparam logic [3:0]  SEG_W_HI    = 4'd7;
    localparam logic [3:0]  SEG_W_LO    = 4'd8;
    localparam logic [3:0]  SEG_END     = 4'd9;

    localparam logic [3:0]  FMT_ENABLE_RESET = 4'hF;

    // Byte i of the signature sits in sig[8i+7:8i].
    function automatic t_image_type classify(input logic [63:0] sig, input logic [3:0] en);
        t_image_type t;
        if (en[EN_JPEG] && sig[7:0] == JPEG_MARK && sig[15:8] == JPEG_SOI &&
            sig[23:16] == JPEG_MARK) begin
            t = IMG_JPEG;
        end else if (en[EN_BMP] && sig[15:0] == BMP_SIG) begin
            t = IMG_BMP;
        end else if (en[EN_PNG] && sig == PNG_SIG) begin
            t = IMG_PNG;
        end else if (en[EN_GIF] && sig[31:0] == GIF_SIG) begin
            t = IMG_GIF;
        end else begin
            t = IMG_UNKNOWN;
        end
        return t;
    endfunction

endpackage

// ----- hw/rtl/ihs_byte_if.sv -----
// Byte stream channel of the image header sniffer: valid/ready, one file
// byte and its last flag. Depends on nothing.
interface ihs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/ihs_result_if.sv -----
// Result channel of the image header sniffer: valid/ready, image type and
// dimensions. Depends on ihs_pkg for the type encoding.
interface ihs_result_if
    import ihs_pkg::*;
;
    logic        valid;
    logic        ready;
    t_image_type image_type;
    logic [31:0] width;
    logic [31:0] height;
    logic        usable;

    modport source (output valid, output image_type, output width, output height,
                    output usable, input ready);
    modport sink   (input valid, input image_type, input width, input height,
                    input usable, output ready);
endinterface

// ----- hw/rtl/image_header_sniffer_unit.sv -----
// Image header sniffer: takes a file one byte per cycle and, in the cycle after
// the byte marked last is taken, presents the detected image type and its width
// and height in a result register. A byte is taken in every cycle in which the
// result register is empty or being drained, so the unit sustains one byte per
// clock; all per-byte work is compare and capture logic ahead of the state and
// result registers. The user must write the format enable register only between
// files; the block does not enforce it. File state clears on the transaction
// carrying the last byte. Depends on ihs_pkg, ihs_byte_if and ihs_result_if.
module image_header_sniffer_unit
    import ihs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata,
    ihs_byte_if.sink            i_byte_if,
    ihs_result_if.source        o_result_if
);

    logic [3:0]  r_fmt_en;
    logic [4:0]  r_byte_pos;
    logic [63:0] r_sig;
    logic [63:0] r_dims;
    logic        r_prev_ff;
    logic [3:0]  r_seg_pos;
    logic [31:0] r_seg_dims;
    logic [31:0] r_jpeg_dims;

    logic [4:0]  n_byte_pos;
    logic [63:0] n_sig;
    logic [63:0] n_dims;
    logic        n_prev_ff;
    logic [3:0]  n_seg_pos;
    logic [31:0] n_seg_dims;
    logic [31:0] n_jpeg_dims;

    logic        r_out_valid;
    t_image_type r_out_type;
    logic [31:0] r_out_width;
    logic [31:0] r_out_height;
    logic        r_out_usable;

    t_image_type n_out_type;
    logic [31:0] n_out_width;
    logic [31:0] n_out_height;
    logic        n_out_usable;

    logic        accept;
    logic [7:0]  b;
    t_image_type dim_type;
    logic [4:0]  bmp_off;
    logic [4:0]  png_off;

    assign b      = i_byte_if.data_byte;
    assign accept = i_byte_if.valid && i_byte_if.ready;

    assign i_byte_if.ready = !r_out_valid || o_result_if.ready;

    assign bmp_off  = 5'(r_byte_pos - POS_BMP_DIM);
    assign png_off  = 5'(r_byte_pos - POS_PNG_DIM);

    always_comb begin
        n_sig = r_sig;
        if (r_byte_pos < POS_SIG_END) begin
            n_sig[{r_byte_pos[2:0], 3'b000} +: 8] = b;
        end
    end

    assign dim_type = classify(n_sig, r_fmt_en);

    always_comb begin
        n_dims = r_dims;
        if (r_byte_pos >= POS_PNG_DIM && r_byte_pos <= POS_BMP_END) begin
            if (dim_type == IMG_BMP && r_byte_pos >= POS_BMP_DIM) begin
                n_dims[{bmp_off[2:0], 3'b000} +: 8] = b;
            end else if (dim_type == IMG_PNG && r_byte_pos <= POS_PNG_END) begin
                n_dims[{png_off[2:0], 3'b000} +: 8] = b;
            end
        end
    end

    assign n_byte_pos = (r_byte_pos < POS_MAX) ? 5'(r_byte_pos + 5'd1) : r_byte_pos;

    always_comb begin
        n_seg_pos   = r_seg_pos;
        n_seg_dims  = r_seg_dims;
        n_jpeg_dims = r_jpeg_dims;
        n_prev_ff   = r_prev_ff;
        if (r_seg_pos != SEG_IDLE) begin
            unique case (r_seg_pos)
                SEG_H_HI: n_seg_dims[31:24] = b;
                SEG_H_LO: n_seg_dims[23:16] = b;
                SEG_W_HI: n_seg_dims[15:8]  = b;
                SEG_W_LO: n_seg_dims[7:0]   = b;
                default: ;
            endcase
            if (r_seg_pos >= SEG_END) begin
                n_jpeg_dims = n_seg_dims;
                n_seg_pos   = SEG_IDLE;
            end else begin
                n_seg_pos = 4'(r_seg_pos + 4'd1);
            end
            n_prev_ff = 1'b0;
        end else if (r_prev_ff && b == JPEG_SOF0) begin
            n_seg_pos  = SEG_FIRST;
            n_seg_dims = '0;
            n_prev_ff  = 1'b0;
        end else begin
            n_prev_ff = (b == JPEG_MARK);
        end
    end

    always_comb begin
        n_out_type   = (r_byte_pos >= POS_LAST_SIG) ? dim_type : IMG_UNKNOWN;
        n_out_width  = '0;
        n_out_height = '0;
        unique case (n_out_type)
            IMG_JPEG: begin
                n_out_width  = {16'd0, n_jpeg_dims[15:0]};
                n_out_height = {16'd0, n_jpeg_dims[31:16]};
            end
            IMG_BMP: begin
                n_out_width  = n_dims[31:0];
                n_out_height = n_dims[63:32];
            end
            IMG_PNG: begin
                n_out_width  = {n_dims[7:0], n_dims[15:8], n_dims[23:16], n_dims[31:24]};
                n_out_height = {n_dims[39:32], n_dims[47:40], n_dims[55:48], n_dims[63:56]};
            end
            default: ;
        endcase
        n_out_usable = (n_out_type != IMG_UNKNOWN) && (n_out_width != '0) &&
                       (n_out_height != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_en <= FMT_ENABLE_RESET;
        end else if (i_cfg_we) begin
            r_fmt_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_sig       <= '0;
            r_dims      <= '0;
            r_prev_ff   <= 1'b0;
            r_seg_pos   <= SEG_IDLE;
            r_seg_dims  <= '0;
            r_jpeg_dims <= '0;
        end else if (accept) begin
            if (i_byte_if.last_byte) begin
                r_byte_pos  <= '0;
                r_sig       <= '0;
                r_dims      <= '0;
                r_prev_ff   <= 1'b0;
                r_seg_pos   <= SEG_IDLE;
                r_seg_dims  <= '0;
                r_jpeg_dims <= '0;
            end else begin
                r_byte_pos  <= n_byte_pos;
                r_sig       <= n_sig;
                r_dims      <= n_dims;
                r_prev_ff   <= n_prev_ff;
                r_seg_pos   <= n_seg_pos;
                r_seg_dims  <= n_seg_dims;
                r_jpeg_dims <= n_jpeg_dims;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_byte_if.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_result_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_byte_if.last_byte) begin
            r_out_type   <= n_out_type;
            r_out_width  <= n_out_width;
            r_out_height <= n_out_height;
            r_out_usable <= n_out_usable;
        end
    end

    assign o_result_if.valid      = r_out_valid;
    assign o_result_if.image_type = r_out_type;
    assign o_result_if.width      = r_out_width;
    assign o_result_if.height     = r_out_height;
    assign o_result_if.usable     = r_out_usable;

endmodule

// ----- hw/rtl/ihs_checker.sv -----
// Port-level checks for image_header_sniffer_unit, attached by bind.
// Depends on ihs_pkg for the type codes.
module ihs_checker
    import ihs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_image_type i_out_type,
    input  logic [31:0] i_out_width,
    input  logic [31:0] i_out_height,
    input  logic        i_out_usable
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("no result after last byte");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    a_usable_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_usable == ((i_out_type != IMG_UNKNOWN) &&
                         (i_out_width != '0) && (i_out_height != '0))))
        else $error("usable flag inconsistent with type and size");

    a_no_size_untyped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_type == IMG_UNKNOWN || i_out_type == IMG_GIF) |->
        (i_out_width == '0) && (i_out_height == '0))
        else $error("size reported for unknown or GIF file");

endmodule

bind image_header_sniffer_unit ihs_checker u_ihs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_byte_if.valid),
    .i_in_ready   (i_byte_if.ready),
    .i_in_last    (i_byte_if.last_byte),
    .i_out_valid  (o_result_if.valid),
    .i_out_ready  (o_result_if.ready),
    .i_out_type   (o_result_if.image_type),
    .i_out_width  (o_result_if.width),
    .i_out_height (o_result_if.height),
    .i_out_usable (o_result_if.usable)
);
